// ----- sv/rfa_pkg.sv -----
// shared constants for the rational fraction alu
`default_nettype none
package rfa_pkg;
   localparam int DW = 32;
   localparam int KW = $clog2(DW);

   localparam logic [2:0] CMD_ADD = 3'd0;
   localparam logic [2:0] CMD_SUB = 3'd1;
   localparam logic [2:0] CMD_MUL = 3'd2;
   localparam logic [2:0] CMD_DIV = 3'd3;
   localparam logic [2:0] CMD_CMP = 3'd4;
   localparam logic [2:0] CMD_SIMP = 3'd5;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_ZERO_DEN = 2'd1;
   localparam logic [1:0] ST_OVF = 2'd2;

   localparam logic signed [1:0] ORD_LESS = -2'sd1;
   localparam logic signed [1:0] ORD_EQUAL = 2'sd0;
   localparam logic signed [1:0] ORD_GREATER = 2'sd1;
endpackage
`default_nettype wire

// ----- sv/rfa_gcd.sv -----
// iterative binary gcd of two magnitudes, gcd of two zeros gives one
`default_nettype none
module rfa_gcd
   import rfa_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] a,
   input  wire logic [DW-1:0] b,
   output logic               done,
   output logic [DW-1:0]      res
);
   typedef enum logic {G_IDLE, G_RUN} gstate_type;

   gstate_type    state_ff;
   logic [DW-1:0] u_ff, v_ff, res_ff;
   logic [KW-1:0] k_ff;
   logic          done_ff;
   logic [DW-1:0] uv;
   logic [DW-1:0] u_sub_v, v_sub_u;

   assign uv = u_ff | v_ff;
   assign u_sub_v = u_ff - v_ff;
   assign v_sub_u = v_ff - u_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            G_IDLE: begin
               if (start) begin
                  u_ff <= a;
                  v_ff <= b;
                  k_ff <= '0;
                  state_ff <= G_RUN;
               end
            end
            G_RUN: begin
               if (u_ff == '0 || v_ff == '0) begin
                  res_ff <= (uv == '0) ? DW'(1) : (uv << k_ff);
                  done_ff <= 1'b1;
                  state_ff <= G_IDLE;
               end else if (!u_ff[0] && !v_ff[0]) begin
                  u_ff <= u_ff >> 1;
                  v_ff <= v_ff >> 1;
                  k_ff <= k_ff + KW'(1);
               end else if (!u_ff[0]) begin
                  u_ff <= u_ff >> 1;
               end else if (!v_ff[0]) begin
                  v_ff <= v_ff >> 1;
               end else if (u_ff >= v_ff) begin
                  u_ff <= u_sub_v >> 1;
               end else begin
                  v_ff <= v_sub_u >> 1;
               end
            end
            default: state_ff <= G_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign res = res_ff;
endmodule
`default_nettype wire

// ----- sv/rfa_div.sv -----
// restoring divider, one quotient bit per cycle
`default_nettype none
module rfa_div
   import rfa_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic               done,
   output logic [DW-1:0]      quo
);
   typedef enum logic {D_IDLE, D_RUN} dstate_type;

   dstate_type    state_ff;
   logic [DW-1:0] rem_ff, quo_ff, den_ff;
   logic [KW:0]   cnt_ff;
   logic          done_ff;
   logic [DW:0]   shifted;
   logic          fits_bit;

   assign shifted = {rem_ff, quo_ff[DW-1]};
   assign fits_bit = shifted >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            D_IDLE: begin
               if (start) begin
                  rem_ff <= '0;
                  quo_ff <= num;
                  den_ff <= den;
                  cnt_ff <= '0;
                  state_ff <= D_RUN;
               end
            end
            D_RUN: begin
               rem_ff <= fits_bit ? DW'(shifted - {1'b0, den_ff}) : shifted[DW-1:0];
               quo_ff <= {quo_ff[DW-2:0], fits_bit};
               cnt_ff <= cnt_ff + (KW+1)'(1);
               if (cnt_ff == (KW+1)'(DW - 1)) begin
                  done_ff <= 1'b1;
                  state_ff <= D_IDLE;
               end
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign quo = quo_ff;
endmodule
`default_nettype wire

// ----- sv/rfa_mul.sv -----
// shift and add multiplier, one partial product per cycle
`default_nettype none
module rfa_mul
   import rfa_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [DW-1:0]   op_a,
   input  wire logic [DW-1:0]   op_b,
   output logic                 done,
   output logic [2*DW-1:0]      prod
);
   typedef enum logic {M_IDLE, M_RUN} mstate_type;

   mstate_type      state_ff;
   logic [2*DW-1:0] acc_ff, mcand_ff;
   logic [DW-1:0]   mplier_ff;
   logic [KW:0]     cnt_ff;
   logic            done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            M_IDLE: begin
               if (start) begin
                  acc_ff <= '0;
                  mcand_ff <= {{DW{1'b0}}, op_a};
                  mplier_ff <= op_b;
                  cnt_ff <= '0;
                  state_ff <= M_RUN;
               end
            end
            M_RUN: begin
               if (mplier_ff[0]) acc_ff <= acc_ff + mcand_ff;
               mcand_ff <= mcand_ff << 1;
               mplier_ff <= mplier_ff >> 1;
               cnt_ff <= cnt_ff + (KW+1)'(1);
               if (cnt_ff == (KW+1)'(DW - 1)) begin
                  done_ff <= 1'b1;
                  state_ff <= M_IDLE;
               end
            end
            default: state_ff <= M_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;
endmodule
`default_nettype wire

// ----- sv/rational_fraction_alu_unit.sv -----
// rational fraction alu top level: sequencer around shared gcd, divider and multiplier
// work per transaction: up to four gcd runs (one bit step a cycle), up to eight divisions
// and up to three multiplications
// throughput: one transaction at a time; req_stall is high from acceptance until the
// result is placed in the output register
// reset: synchronous, active high; clears the sequencer, the units and rsp_valid
`default_nettype none
module rational_fraction_alu_unit
   import rfa_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_cmd,
   input  wire logic signed [31:0] req_a_num,
   input  wire logic signed [31:0] req_a_den,
   input  wire logic signed [31:0] req_b_num,
   input  wire logic signed [31:0] req_b_den,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_res_num,
   output logic [30:0]             rsp_res_den,
   output logic signed [31:0]      rsp_alt_num,
   output logic [30:0]             rsp_alt_den,
   output logic signed [1:0]       rsp_order,
   output logic [1:0]              rsp_status
);
   localparam int RB = (WIDTH < 32) ? WIDTH : 32;
   localparam int SW = 2 * DW + 2;
   localparam logic [SW-1:0] LIM = SW'(1) << (RB - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_RG, S_RGW, S_RDX, S_RDXW, S_RDY, S_RDYW, S_M, S_MW, S_FIN
   } state_type;
   typedef enum logic [2:0] {PH_A, PH_B, PH_X, PH_Y, PH_L} phase_type;

   state_type  state_ff, state_in;
   phase_type  phase_ff, phase_in;
   logic [2:0] cmd_ff, cmd_in;
   logic [31:0] bn_ff, bn_in, bd_ff, bd_in;
   logic [DW-1:0] rx_ff, rx_in, ry_ff, ry_in, g_ff, g_in;
   logic rs_ff, rs_in;
   logic [DW-1:0] n1m_ff, n1m_in, d1m_ff, d1m_in, n2m_ff, n2m_in, d2m_ff, d2m_in;
   logic n1s_ff, n1s_in, n2s_ff, n2s_in;
   logic [1:0] mstep_ff, mstep_in;
   logic [2*DW-1:0] p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] res_num_ff, res_num_in, alt_num_ff, alt_num_in;
   logic [30:0] res_den_ff, res_den_in, alt_den_ff, alt_den_in;
   logic signed [1:0] order_ff, order_in;
   logic [1:0] status_ff, status_in;

   logic gcd_start, gcd_done, div_start, div_done, mul_start, mul_done;
   logic [DW-1:0] gcd_res, div_num, div_quo, mul_a, mul_b;
   logic [2*DW-1:0] mul_prod;
   logic is_arith, is_sub;

   logic [SW-1:0] t1, t2, st1, st2, sum, sum_mag;
   logic sum_neg;
   logic signed [31:0] f_num, f_alt;
   logic [30:0] f_den, f_alt_den;
   logic signed [1:0] f_order;
   logic [1:0] f_status;

   function automatic logic [DW-1:0] mag32(input logic [31:0] v);
      return v[31] ? DW'(-v) : DW'(v);
   endfunction

   function automatic logic fits(input logic neg, input logic [SW-1:0] m,
                                 input logic [SW-1:0] d);
      return (neg ? (m <= LIM) : (m < LIM)) && (d < LIM);
   endfunction

   function automatic logic [31:0] signum(input logic neg, input logic [SW-1:0] m);
      return neg ? 32'(-m) : 32'(m);
   endfunction

   rfa_gcd u_gcd (
      .clock(clock), .reset(reset), .start(gcd_start),
      .a(rx_ff), .b(ry_ff), .done(gcd_done), .res(gcd_res)
   );

   rfa_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(div_num), .den(g_ff), .done(div_done), .quo(div_quo)
   );

   rfa_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start),
      .op_a(mul_a), .op_b(mul_b), .done(mul_done), .prod(mul_prod)
   );

   assign is_arith = (cmd_ff == CMD_ADD) || (cmd_ff == CMD_SUB) || (cmd_ff == CMD_CMP);
   assign is_sub = (cmd_ff == CMD_SUB) || (cmd_ff == CMD_CMP);
   assign div_num = (state_ff == S_RDX) ? rx_ff : ry_ff;
   assign gcd_start = (state_ff == S_RG);
   assign div_start = (state_ff == S_RDX) || (state_ff == S_RDY);
   assign mul_start = (state_ff == S_M);

   always_comb begin
      mul_a = n2m_ff;
      mul_b = n1m_ff;
      if (is_arith) begin
         unique case (mstep_ff)
            2'd0: begin mul_a = rx_ff; mul_b = d2m_ff; end
            2'd1: begin mul_a = ry_ff; mul_b = n1m_ff; end
            default: begin mul_a = rx_ff; mul_b = n2m_ff; end
         endcase
      end else if (mstep_ff != 2'd0) begin
         mul_a = d1m_ff;
         mul_b = d2m_ff;
      end
   end

   // final result from the stored products, or from the reduced fractions for simplify
   always_comb begin
      t1 = {2'b00, p1_ff};
      t2 = {2'b00, p2_ff};
      st1 = n1s_ff ? -t1 : t1;
      st2 = (n2s_ff ^ is_sub) ? -t2 : t2;
      sum = st1 + st2;
      sum_neg = sum[SW-1];
      sum_mag = sum_neg ? -sum : sum;
      f_num = '0;
      f_den = '0;
      f_alt = '0;
      f_alt_den = '0;
      f_order = ORD_EQUAL;
      f_status = ST_OK;
      unique case (cmd_ff)
         CMD_ADD, CMD_SUB, CMD_CMP: begin
            if (d1m_ff == '0 || d2m_ff == '0) begin
               f_status = ST_ZERO_DEN;
            end else if (cmd_ff == CMD_CMP) begin
               f_order = sum_neg ? ORD_LESS : ((sum != '0) ? ORD_GREATER : ORD_EQUAL);
            end else if (!fits(sum_neg, sum_mag, {2'b00, p0_ff})) begin
               f_status = ST_OVF;
            end else begin
               f_num = signum(sum_neg, sum_mag);
               f_den = p0_ff[30:0];
            end
         end
         CMD_MUL, CMD_DIV: begin
            if (!fits(n1s_ff ^ n2s_ff, {2'b00, p0_ff}, {2'b00, p1_ff})) begin
               f_status = ST_OVF;
            end else begin
               f_num = signum(n1s_ff ^ n2s_ff, {2'b00, p0_ff});
               f_den = p1_ff[30:0];
            end
         end
         CMD_SIMP: begin
            if (!fits(n1s_ff, SW'(n1m_ff), SW'(d1m_ff))
                || !fits(n2s_ff, SW'(n2m_ff), SW'(d2m_ff))) begin
               f_status = ST_OVF;
            end else begin
               f_num = signum(n1s_ff, SW'(n1m_ff));
               f_den = d1m_ff[30:0];
               f_alt = signum(n2s_ff, SW'(n2m_ff));
               f_alt_den = d2m_ff[30:0];
            end
         end
         default: f_status = ST_OK;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cmd_in = cmd_ff;
      bn_in = bn_ff;
      bd_in = bd_ff;
      rx_in = rx_ff;
      ry_in = ry_ff;
      rs_in = rs_ff;
      g_in = g_ff;
      n1m_in = n1m_ff;
      n1s_in = n1s_ff;
      d1m_in = d1m_ff;
      n2m_in = n2m_ff;
      n2s_in = n2s_ff;
      d2m_in = d2m_ff;
      mstep_in = mstep_ff;
      p0_in = p0_ff;
      p1_in = p1_ff;
      p2_in = p2_ff;
      res_num_in = res_num_ff;
      res_den_in = res_den_ff;
      alt_num_in = alt_num_ff;
      alt_den_in = alt_den_ff;
      order_in = order_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in = req_cmd;
               bn_in = req_b_num;
               bd_in = req_b_den;
               rx_in = mag32(req_a_num);
               ry_in = mag32(req_a_den);
               rs_in = req_a_num[31] ^ req_a_den[31];
               phase_in = PH_A;
               state_in = S_RG;
            end
         end
         S_RG: state_in = S_RGW;
         S_RGW: begin
            if (gcd_done) begin
               g_in = gcd_res;
               state_in = S_RDX;
            end
         end
         S_RDX: state_in = S_RDXW;
         S_RDXW: begin
            if (div_done) begin
               rx_in = div_quo;
               state_in = S_RDY;
            end
         end
         S_RDY: state_in = S_RDYW;
         S_RDYW: begin
            if (div_done) begin
               ry_in = div_quo;
               unique case (phase_ff)
                  PH_A: begin
                     n1m_in = rx_ff;
                     n1s_in = rs_ff;
                     d1m_in = div_quo;
                     if (cmd_ff == CMD_DIV) begin
                        rx_in = mag32(bd_ff);
                        ry_in = mag32(bn_ff);
                     end else begin
                        rx_in = mag32(bn_ff);
                        ry_in = mag32(bd_ff);
                     end
                     rs_in = bn_ff[31] ^ bd_ff[31];
                     phase_in = PH_B;
                     state_in = S_RG;
                  end
                  PH_B: begin
                     n2m_in = rx_ff;
                     n2s_in = rs_ff;
                     d2m_in = div_quo;
                     if (cmd_ff == CMD_MUL || cmd_ff == CMD_DIV) begin
                        ry_in = d1m_ff;
                        phase_in = PH_X;
                        state_in = S_RG;
                     end else if (is_arith && d1m_ff != '0 && div_quo != '0) begin
                        rx_in = d1m_ff;
                        phase_in = PH_L;
                        state_in = S_RG;
                     end else begin
                        state_in = S_FIN;
                     end
                  end
                  PH_X: begin
                     n2m_in = rx_ff;
                     n2s_in = rs_ff;
                     d1m_in = div_quo;
                     rx_in = n1m_ff;
                     ry_in = d2m_ff;
                     rs_in = n1s_ff;
                     phase_in = PH_Y;
                     state_in = S_RG;
                  end
                  PH_Y: begin
                     n1m_in = rx_ff;
                     n1s_in = rs_ff;
                     d2m_in = div_quo;
                     mstep_in = 2'd0;
                     state_in = S_M;
                  end
                  PH_L: begin
                     mstep_in = 2'd0;
                     state_in = S_M;
                  end
                  default: state_in = S_FIN;
               endcase
            end
         end
         S_M: state_in = S_MW;
         S_MW: begin
            if (mul_done) begin
               unique case (mstep_ff)
                  2'd0: p0_in = mul_prod;
                  2'd1: p1_in = mul_prod;
                  default: p2_in = mul_prod;
               endcase
               if ((is_arith && mstep_ff == 2'd2) || (!is_arith && mstep_ff == 2'd1)) begin
                  state_in = S_FIN;
               end else begin
                  mstep_in = mstep_ff + 2'd1;
                  state_in = S_M;
               end
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               res_num_in = f_num;
               res_den_in = f_den;
               alt_num_in = f_alt;
               alt_den_in = f_alt_den;
               order_in = f_order;
               status_in = f_status;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_A;
         mstep_ff <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         mstep_ff <= mstep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      bn_ff <= bn_in;
      bd_ff <= bd_in;
      rx_ff <= rx_in;
      ry_ff <= ry_in;
      rs_ff <= rs_in;
      g_ff <= g_in;
      n1m_ff <= n1m_in;
      n1s_ff <= n1s_in;
      d1m_ff <= d1m_in;
      n2m_ff <= n2m_in;
      n2s_ff <= n2s_in;
      d2m_ff <= d2m_in;
      p0_ff <= p0_in;
      p1_ff <= p1_in;
      p2_ff <= p2_in;
      res_num_ff <= res_num_in;
      res_den_ff <= res_den_in;
      alt_num_ff <= alt_num_in;
      alt_den_ff <= alt_den_in;
      order_ff <= order_in;
      status_ff <= status_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_res_num = res_num_ff;
   assign rsp_res_den = res_den_ff;
   assign rsp_alt_num = alt_num_ff;
   assign rsp_alt_den = alt_den_ff;
   assign rsp_order = order_ff;
   assign rsp_status = status_ff;
endmodule
`default_nettype wire
